[design/cutc_pkg.sv]
// Shared types, constants and calendar tables for the calendar / Unix time converter.
// No dependencies; compiled first.
`default_nettype none

package cutc_pkg;

  localparam int CUTC_DEPTH = 10;

  localparam logic        OP_DATE_TO_SECS = 1'b0;
  localparam logic        OP_SECS_TO_DATE = 1'b1;

  localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
  localparam logic [11:0] LAST_YEAR          = 12'd2099;
  localparam logic [8:0]  LEAPS_BEFORE_EPOCH = 9'd492;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [10:0] DAYS_2Y            = 11'd730;
  localparam logic [10:0] DAYS_3Y            = 11'd1095;
  localparam logic [10:0] DAYS_PER_CYCLE     = 11'd1461;
  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN       = 6'd60;
  localparam logic [4:0]  MAX_HOUR           = 5'd23;
  localparam logic [5:0]  MAX_MIN_SEC        = 6'd59;
  localparam logic [31:0] MAX_UNIX           = 32'd4102444799;

  // floor(2^k / d) reciprocals; estimates are at most one low
  localparam logic [25:0] DAY_RECIP   = 26'd50903316;  // 2^35 / 675, on t >> 7
  localparam logic [16:0] CYCLE_RECIP = 17'd91867;     // 2^27 / 1461
  localparam logic [17:0] HOUR_RECIP  = 18'd149130;    // 2^29 / 3600
  localparam logic [14:0] MIN_RECIP   = 15'd17476;     // 2^20 / 60

  typedef struct packed {
    logic        opcode;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hours;
    logic [5:0]  in_minutes;
    logic [5:0]  in_seconds;
    logic [31:0] in_unix_seconds;
  } cutc_in_t;

  typedef struct packed {
    logic [31:0] out_unix_seconds;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hours;
    logic [5:0]  out_minutes;
    logic [5:0]  out_seconds;
    logic        range_error;
  } cutc_out_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month) inside
      4'd2:                                  n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:               n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      default:                               n = 5'd0;
    endcase
    return n;
  endfunction

  // days of the year before the first of the month
  function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
    logic [8:0] n;
    case (month)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n + {8'd0, leap && (month > 4'd2) && (month <= 4'd12)};
  endfunction

endpackage

`default_nettype wire

[design/cutc_if.sv]
// Valid/ready channel interfaces for the converter's input and result beats.
// Depends on cutc_pkg.
`default_nettype none

interface cutc_in_if;
  import cutc_pkg::*;
  logic     valid;
  logic     ready;
  cutc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cutc_out_if;
  import cutc_pkg::*;
  logic      valid;
  logic      ready;
  cutc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/cutc_stages.sv]
// Payload pipeline of the converter: nine working stages and the result register.
// Depends on cutc_pkg; advanced by the top level's stall control.
`default_nettype none

module cutc_stages (
  input  logic                clk,
  input  logic                adv,
  input  cutc_pkg::cutc_in_t  in_beat,
  output cutc_pkg::cutc_out_t out_beat
);
  import cutc_pkg::*;

  typedef struct packed {
    logic        opcode;
    logic        err;
    // date to seconds
    logic [4:0]  day;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [15:0] days_yr;
    logic [8:0]  doy_pre;
    logic [15:0] days_f;
    logic [16:0] hms;
    logic [31:0] prod;
    logic [31:0] fsecs;
    // seconds to date
    logic [31:0] t;
    logic [50:0] p1;
    logic [15:0] q0;
    logic [31:0] p2;
    logic [15:0] days_r;
    logic [16:0] rem;
    logic [15:0] dd;
    logic [32:0] p3;
    logic [34:0] p4;
    logic [5:0]  q4;
    logic [15:0] m4;
    logic [4:0]  hr;
    logic [16:0] mh;
    logic [10:0] r4c;
    logic [11:0] r2c;
    logic [26:0] p5;
    logic [1:0]  yi;
    logic [8:0]  doy;
    logic [11:0] oyear;
    logic        leap;
    logic [3:0]  omonth;
    logic [8:0]  mstart;
    logic [5:0]  mi;
    logic [11:0] mm60;
    logic [4:0]  oday;
    logic [5:0]  osec;
  } work_t;

  localparam int NW = CUTC_DEPTH - 1;

  work_t     st_r   [1:NW];
  work_t     st_nxt [1:NW];
  cutc_out_t out_r, out_nxt;

  function automatic work_t stage1(input cutc_in_t i);
    work_t       w;
    logic        lp;
    logic        ok_f;
    logic [11:0] yoff;
    logic [11:0] ym1;
    w       = '0;
    lp      = (i.in_year[1:0] == 2'd0);
    ok_f    = (i.in_year >= EPOCH_YEAR) && (i.in_year <= LAST_YEAR) &&
              (i.in_day != 5'd0) && (i.in_day <= month_len(i.in_month, lp)) &&
              (i.in_hours <= MAX_HOUR) && (i.in_minutes <= MAX_MIN_SEC) &&
              (i.in_seconds <= MAX_MIN_SEC);
    yoff    = i.in_year - EPOCH_YEAR;
    ym1     = i.in_year - 12'd1;
    w.opcode  = i.opcode;
    w.err     = (i.opcode == OP_SECS_TO_DATE) ? (i.in_unix_seconds > MAX_UNIX) : !ok_f;
    w.days_yr = 16'(yoff) * 16'(DAYS_PER_YEAR) + 16'(ym1[11:2]) - 16'(LEAPS_BEFORE_EPOCH);
    w.doy_pre = month_start(i.in_month, lp);
    w.day     = i.in_day;
    w.hh      = i.in_hours;
    w.mm      = i.in_minutes;
    w.ss      = i.in_seconds;
    w.t       = i.in_unix_seconds;
    w.p1      = 51'(i.in_unix_seconds[31:7]) * 51'(DAY_RECIP);
    return w;
  endfunction

  function automatic work_t stage2(input work_t p);
    work_t w;
    w        = p;
    w.days_f = p.days_yr + 16'(p.doy_pre) + 16'(p.day) - 16'd1;
    w.hms    = 17'(p.hh) * 17'(SECS_PER_HOUR) + 17'(p.mm) * 17'(SECS_PER_MIN) + 17'(p.ss);
    w.q0     = p.p1[50:35];
    w.p2     = 32'(p.p1[50:35]) * 32'(SECS_PER_DAY);
    return w;
  endfunction

  function automatic work_t stage3(input work_t p);
    work_t       w;
    logic [31:0] diff;
    logic [17:0] r;
    w      = p;
    w.prod = 32'(p.days_f) * 32'(SECS_PER_DAY);
    diff   = p.t - p.p2;
    r      = diff[17:0];
    if (r >= 18'(SECS_PER_DAY)) begin
      w.days_r = p.q0 + 16'd1;
      w.rem    = 17'(r - 18'(SECS_PER_DAY));
    end else begin
      w.days_r = p.q0;
      w.rem    = r[16:0];
    end
    return w;
  endfunction

  function automatic work_t stage4(input work_t p);
    work_t       w;
    logic [15:0] d;
    w       = p;
    w.fsecs = p.prod + 32'(p.hms);
    d       = p.days_r + 16'(DAYS_PER_YEAR);   // cycles start on 1969-01-01
    w.dd    = d;
    w.p3    = 33'(d) * 33'(CYCLE_RECIP);
    w.p4    = 35'(p.rem) * 35'(HOUR_RECIP);
    return w;
  endfunction

  function automatic work_t stage5(input work_t p);
    work_t w;
    w    = p;
    w.q4 = p.p3[32:27];
    w.m4 = 16'(p.p3[32:27]) * 16'(DAYS_PER_CYCLE);
    w.hr = p.p4[33:29];
    w.mh = 17'(p.p4[33:29]) * 17'(SECS_PER_HOUR);
    return w;
  endfunction

  function automatic work_t stage6(input work_t p);
    work_t       w;
    logic [15:0] d4;
    logic [11:0] r4;
    logic [16:0] d2;
    logic [12:0] r2;
    w  = p;
    d4 = p.dd - p.m4;
    r4 = d4[11:0];
    if (r4 >= 12'(DAYS_PER_CYCLE)) begin
      w.q4  = p.q4 + 6'd1;
      w.r4c = 11'(r4 - 12'(DAYS_PER_CYCLE));
    end else begin
      w.r4c = r4[10:0];
    end
    d2 = p.rem - p.mh;
    r2 = d2[12:0];
    if (r2 >= 13'(SECS_PER_HOUR)) begin
      w.hr  = p.hr + 5'd1;
      w.r2c = 12'(r2 - 13'(SECS_PER_HOUR));
    end else begin
      w.r2c = r2[11:0];
    end
    return w;
  endfunction

  function automatic work_t stage7(input work_t p);
    work_t      w;
    logic [1:0] y;
    w       = p;
    // last year of each four-year cycle is the leap year
    y       = 2'(p.r4c >= 11'(DAYS_PER_YEAR)) + 2'(p.r4c >= DAYS_2Y) + 2'(p.r4c >= DAYS_3Y);
    w.yi    = y;
    w.leap  = (y == 2'd3);
    w.doy   = 9'(p.r4c - 11'(y) * 11'(DAYS_PER_YEAR));
    w.oyear = (EPOCH_YEAR - 12'd1) + {4'd0, p.q4, 2'b00} + 12'(y);
    w.p5    = 27'(p.r2c) * 27'(MIN_RECIP);
    return w;
  endfunction

  function automatic work_t stage8(input work_t p);
    work_t      w;
    logic [3:0] cnt;
    w   = p;
    cnt = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      cnt = cnt + 4'(p.doy >= month_start(4'(m), p.leap));
    end
    w.omonth = cnt;
    w.mstart = month_start(cnt, p.leap);
    w.mi     = p.p5[25:20];
    w.mm60   = 12'(p.p5[25:20]) * 12'(SECS_PER_MIN);
    return w;
  endfunction

  function automatic work_t stage9(input work_t p);
    work_t       w;
    logic [8:0]  dm;
    logic [11:0] ds;
    w    = p;
    dm   = p.doy - p.mstart + 9'd1;
    w.oday = dm[4:0];
    ds   = p.r2c - p.mm60;
    if (ds >= 12'(SECS_PER_MIN)) begin
      w.mi   = p.mi + 6'd1;
      w.osec = 6'(ds - 12'(SECS_PER_MIN));
    end else begin
      w.osec = ds[5:0];
    end
    return w;
  endfunction

  always_comb begin
    st_nxt[1] = stage1(in_beat);
    st_nxt[2] = stage2(st_r[1]);
    st_nxt[3] = stage3(st_r[2]);
    st_nxt[4] = stage4(st_r[3]);
    st_nxt[5] = stage5(st_r[4]);
    st_nxt[6] = stage6(st_r[5]);
    st_nxt[7] = stage7(st_r[6]);
    st_nxt[8] = stage8(st_r[7]);
    st_nxt[9] = stage9(st_r[8]);
  end

  always_comb begin
    out_nxt = '0;
    if (st_r[NW].err) begin
      out_nxt.range_error = 1'b1;
    end else if (st_r[NW].opcode == OP_SECS_TO_DATE) begin
      out_nxt.out_year    = st_r[NW].oyear;
      out_nxt.out_month   = st_r[NW].omonth;
      out_nxt.out_day     = st_r[NW].oday;
      out_nxt.out_hours   = st_r[NW].hr;
      out_nxt.out_minutes = st_r[NW].mi;
      out_nxt.out_seconds = st_r[NW].osec;
    end else begin
      out_nxt.out_unix_seconds = st_r[NW].fsecs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r  <= st_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_beat = out_r;

endmodule

`default_nettype wire

[design/calendar_unix_time_converter.sv]
// Calendar date-time <-> Unix seconds converter, top level: beat handshake and stage valids.
// Depends on cutc_pkg, cutc_if and cutc_stages.
//
// Usage:
//   in_ch carries one request beat: opcode 0 turns year/month/day/hours/minutes/seconds
//   into seconds since 1970-01-01 00:00:00, opcode 1 turns in_unix_seconds into a date.
//   Supported span is 1970 to 2099; anything outside it returns range_error with every
//   other result field zero. The unused direction's fields of a result read as zero.
//   out_ch returns exactly one result beat per request, in request order.
// Timing:
//   Ten register stages, the first loaded on the edge that takes the request; the result
//   is presented on out_ch once it reaches the result register, the last of them.
//   One request is taken per cycle while no result waits on out_ch.ready, so the pipe
//   sustains one item per clock when unstalled. The depth is set by the chain of reciprocal
//   multiplies and corrections for the day, four-year cycle, hour and minute splits.
// Reset and stalls:
//   rst_n (synchronous, active low) empties the pipe; no result is shown afterwards
//   until a new request has passed through. While a result waits on out_ch.ready the
//   whole pipe holds and in_ch.ready is low; nothing is lost or repeated.
`default_nettype none

module calendar_unix_time_converter (
  input  logic        clk,
  input  logic        rst_n,
  cutc_in_if.sink     in_ch,
  cutc_out_if.source  out_ch
);
  import cutc_pkg::*;

  logic [CUTC_DEPTH-1:0] vld_r, vld_nxt;
  logic                  adv;

  assign adv          = !vld_r[CUTC_DEPTH-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[CUTC_DEPTH-1];

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[CUTC_DEPTH-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  cutc_stages u_stages (
    .clk      (clk),
    .adv      (adv),
    .in_beat  (in_ch.data),
    .out_beat (out_ch.data)
  );

endmodule

`default_nettype wire

[design/cutc_checker.sv]
// Port-level assertions for the converter, bound onto the top level.
// Depends on cutc_pkg and calendar_unix_time_converter.
`default_nettype none

module cutc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cutc_pkg::cutc_out_t out_data
);
  import cutc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with an empty output");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |->
      out_data.out_unix_seconds == 32'd0 && out_data.out_year == 12'd0 &&
      out_data.out_month == 4'd0 && out_data.out_day == 5'd0 &&
      out_data.out_hours == 5'd0 && out_data.out_minutes == 6'd0 &&
      out_data.out_seconds == 6'd0)
    else $error("range error with non-zero fields");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.range_error |->
      out_data.out_unix_seconds == 32'd0 ||
      (out_data.out_year == 12'd0 && out_data.out_month == 4'd0 &&
       out_data.out_day == 5'd0 && out_data.out_hours == 5'd0 &&
       out_data.out_minutes == 6'd0 && out_data.out_seconds == 6'd0))
    else $error("both directions populated in one beat");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.range_error && out_data.out_year != 12'd0 |->
      out_data.out_year >= EPOCH_YEAR && out_data.out_year <= LAST_YEAR &&
      out_data.out_month >= 4'd1 && out_data.out_month <= 4'd12 &&
      out_data.out_day >= 5'd1 && out_data.out_hours <= MAX_HOUR &&
      out_data.out_minutes <= MAX_MIN_SEC && out_data.out_seconds <= MAX_MIN_SEC)
    else $error("date result out of calendar range");

endmodule

bind calendar_unix_time_converter cutc_checker u_cutc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

[verif/tb_calendar_unix_time_converter.sv]
// Testbench for calendar_unix_time_converter: directed and random date and seconds beats,
// checked against a built-in calendar predictor. Depends on cutc_pkg and cutc_if.
`timescale 1ns / 100ps

module tb_calendar_unix_time_converter;
  import cutc_pkg::*;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk;
  logic rst_n;

  cutc_in_if  in_ch ();
  cutc_out_if out_ch ();

  calendar_unix_time_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cutc_out_t due_conversions [$];
  int        errors;
  bit        steady;
  int        hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("calendar_unix_time_converter verification failed");
    $finish;
  end

  function automatic int unsigned days_of_month(input int unsigned m, input int unsigned y);
    int unsigned n;
    n = MONTH_DAYS[(m - 1) % 12];
    if (m == 2 && y % 4 == 0) n++;
    return n;
  endfunction

  function automatic cutc_out_t convert_time(input cutc_in_t req);
    cutc_out_t   res;
    int unsigned y, mo, d, h, mi, s, days, t, rem, shifted, q, cyc_rem, yi, doy;
    res = '0;
    if (req.opcode == OP_DATE_TO_SECS) begin
      y = req.in_year;
      mo = req.in_month;
      d = req.in_day;
      h = req.in_hours;
      mi = req.in_minutes;
      s = req.in_seconds;
      if (y < 1970 || y > 2099 || mo < 1 || mo > 12 || d < 1 || d > days_of_month(mo, y) ||
          h > 23 || mi > 59 || s > 59) begin
        res.range_error = 1'b1;
      end else begin
        days = (y - 1970) * 365 + ((y - 1) / 4 - 492);
        for (int unsigned m = 1; m < mo; m++) days += days_of_month(m, y);
        days += d - 1;
        res.out_unix_seconds = days * 86400 + h * 3600 + mi * 60 + s;
      end
    end else begin
      t = req.in_unix_seconds;
      if (t > MAX_UNIX) begin
        res.range_error = 1'b1;
      end else begin
        days = t / 86400;
        rem = t % 86400;
        h = rem / 3600;
        mi = (rem / 60) % 60;
        s = rem % 60;
        // four-year cycles from 1969-01-01, leap year last in each cycle
        shifted = days + 365;
        q = shifted / 1461;
        cyc_rem = shifted % 1461;
        yi = cyc_rem / 365;
        if (yi > 3) yi = 3;
        y = 1969 + 4 * q + yi;
        doy = cyc_rem - 365 * yi;
        mo = 1;
        while (mo < 12 && doy >= days_of_month(mo, y)) begin
          doy -= days_of_month(mo, y);
          mo++;
        end
        res.out_year = y[11:0];
        res.out_month = mo[3:0];
        res.out_day = 5'(doy + 1);
        res.out_hours = h[4:0];
        res.out_minutes = mi[5:0];
        res.out_seconds = s[5:0];
      end
    end
    return res;
  endfunction

  function automatic cutc_in_t date_beat(input int unsigned y, input int unsigned mo,
                                         input int unsigned d, input int unsigned h,
                                         input int unsigned mi, input int unsigned s);
    cutc_in_t b;
    b.opcode = OP_DATE_TO_SECS;
    b.in_year = 12'(y);
    b.in_month = 4'(mo);
    b.in_day = 5'(d);
    b.in_hours = 5'(h);
    b.in_minutes = 6'(mi);
    b.in_seconds = 6'(s);
    b.in_unix_seconds = $urandom;
    return b;
  endfunction

  function automatic cutc_in_t secs_beat(input logic [31:0] t);
    cutc_in_t b;
    b.opcode = OP_SECS_TO_DATE;
    b.in_year = 12'($urandom);
    b.in_month = 4'($urandom);
    b.in_day = 5'($urandom);
    b.in_hours = 5'($urandom);
    b.in_minutes = 6'($urandom);
    b.in_seconds = 6'($urandom);
    b.in_unix_seconds = t;
    return b;
  endfunction

  function automatic cutc_in_t random_date_beat();
    cutc_in_t    b;
    int unsigned y, mo, len, kind;
    y = $urandom_range(1970, 2099);
    mo = $urandom_range(1, 12);
    len = days_of_month(mo, y);
    kind = $urandom_range(0, 9);
    b = date_beat(y, mo, $urandom_range(1, len), $urandom_range(0, 23),
                  $urandom_range(0, 59), $urandom_range(0, 59));
    if (kind == 7) begin
      b.in_day = 5'(len);
      if ($urandom_range(0, 1)) {b.in_hours, b.in_minutes, b.in_seconds} = {5'd23, 6'd59, 6'd59};
    end else if (kind == 8) begin
      case ($urandom_range(0, 5))
        0: b.in_year = $urandom_range(0, 1) ? 12'd1969 : 12'd2100;
        1: b.in_month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
        2: b.in_day = (len == 31 || $urandom_range(0, 1)) ? 5'd0 : 5'($urandom_range(len + 1, 31));
        3: b.in_hours = 5'($urandom_range(24, 31));
        4: b.in_minutes = 6'($urandom_range(60, 63));
        default: b.in_seconds = 6'($urandom_range(60, 63));
      endcase
    end else if (kind == 9) begin
      b = secs_beat($urandom);
      b.opcode = OP_DATE_TO_SECS;
    end
    return b;
  endfunction

  function automatic cutc_in_t random_secs_beat();
    cutc_in_t    b;
    cutc_out_t   month_end;
    logic [31:0] t;
    int unsigned y, mo, kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      t = $urandom_range(0, MAX_UNIX);
    end else if (kind <= 7) begin
      // last second of a random month, then step across into the next
      y = $urandom_range(1970, 2099);
      mo = $urandom_range(1, 12);
      month_end = convert_time(date_beat(y, mo, days_of_month(mo, y), 23, 59, 59));
      t = month_end.out_unix_seconds;
      t = t + $urandom_range(0, 2);
    end else if (kind == 8) begin
      t = MAX_UNIX - 2 + $urandom_range(0, 4);
    end else begin
      t = $urandom_range(0, 1) ? $urandom : $urandom_range(MAX_UNIX + 1, 32'hFFFF_FFFF);
    end
    b = secs_beat(t);
    return b;
  endfunction

  task automatic send_beat(input cutc_in_t beat);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(0, 99) < 23) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= beat;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    due_conversions.push_back(convert_time(beat));
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result checker
  initial begin
    cutc_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (due_conversions.size() == 0) begin
          errors++;
          $display("%0t unexpected beat: expected none, actual %p", $time, out_ch.data);
        end else begin
          want = due_conversions.pop_front();
          compare_field("out_unix_seconds", want.out_unix_seconds, out_ch.data.out_unix_seconds);
          compare_field("out_year", 32'(want.out_year), 32'(out_ch.data.out_year));
          compare_field("out_month", 32'(want.out_month), 32'(out_ch.data.out_month));
          compare_field("out_day", 32'(want.out_day), 32'(out_ch.data.out_day));
          compare_field("out_hours", 32'(want.out_hours), 32'(out_ch.data.out_hours));
          compare_field("out_minutes", 32'(want.out_minutes), 32'(out_ch.data.out_minutes));
          compare_field("out_seconds", 32'(want.out_seconds), 32'(out_ch.data.out_seconds));
          compare_field("range_error", 32'(want.range_error), 32'(out_ch.data.range_error));
        end
      end
    end
  end

  // result receiver, with an optional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (rst_n !== 1'b1) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 23);
      end
    end
  end

  task automatic test_directed();
    send_beat(date_beat(1970, 1, 1, 0, 0, 0));
    send_beat(date_beat(2099, 12, 31, 23, 59, 59));
    send_beat(date_beat(2000, 2, 29, 12, 30, 45));
    send_beat(date_beat(2001, 2, 29, 0, 0, 0));
    send_beat(date_beat(2004, 2, 30, 0, 0, 0));
    send_beat(date_beat(2023, 4, 31, 0, 0, 0));
    send_beat(date_beat(1969, 12, 31, 23, 59, 59));
    send_beat(date_beat(2100, 1, 1, 0, 0, 0));
    send_beat(date_beat(4095, 15, 31, 31, 63, 63));
    send_beat(date_beat(0, 0, 0, 0, 0, 0));
    send_beat(date_beat(2020, 13, 1, 0, 0, 0));
    send_beat(date_beat(2020, 6, 0, 0, 0, 0));
    send_beat(date_beat(2020, 6, 1, 24, 0, 0));
    send_beat(date_beat(2020, 6, 1, 23, 60, 0));
    send_beat(date_beat(2020, 6, 1, 23, 59, 60));
    send_beat(date_beat(2024, 12, 31, 23, 59, 59));
    send_beat(secs_beat(32'd0));
    send_beat(secs_beat(MAX_UNIX));
    send_beat(secs_beat(MAX_UNIX + 1));
    send_beat(secs_beat(32'hFFFF_FFFF));
    send_beat(secs_beat(32'd951782400));
    send_beat(secs_beat(32'd1735689599));
    send_beat(secs_beat(32'd1709251199));
    send_beat(secs_beat(32'd1709251200));
    send_beat(secs_beat(32'd31535999));
  endtask

  task automatic test_random_dates();
    repeat (200) send_beat(random_date_beat());
  endtask

  task automatic test_random_seconds();
    repeat (200) send_beat(random_secs_beat());
  endtask

  task automatic test_back_pressure();
    hold_request = 80;
    repeat (30) send_beat($urandom_range(0, 1) ? random_date_beat() : random_secs_beat());
  endtask

  task automatic test_steady_mix();
    steady = 1'b1;
    repeat (100) send_beat($urandom_range(0, 1) ? random_date_beat() : random_secs_beat());
    steady = 1'b0;
  endtask

  initial begin
    errors = 0;
    steady = 1'b0;
    hold_request = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_dates();
    test_random_seconds();
    test_back_pressure();
    test_steady_mix();

    in_ch.valid <= 1'b0;
    while (due_conversions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("calendar_unix_time_converter verification clean");
    end else begin
      $display("calendar_unix_time_converter verification failed");
    end
    $finish;
  end

endmodule

[calendar_unix_time_converter.f]
design/cutc_pkg.sv
design/cutc_if.sv
design/cutc_stages.sv
design/calendar_unix_time_converter.sv
design/cutc_checker.sv
verif/tb_calendar_unix_time_converter.sv
